@@ rtl/core/oaht_pkg.sv @@
// Shared types and constants for the open-addressing hash table.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package oaht_pkg;

  // Fixed field widths of the command and result beats and of the config data
  localparam int KEY_W    = 16;
  localparam int ADDR_W   = 5;
  localparam int CFG_W    = 6;

  // Table size after reset, before clamping to the physical depth
  localparam int TABLE_SIZE_RESET = 32;

  // Configuration register indexes
  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_PROBE_MODE = 1'b1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INSERTED  = 4'd0,
    ST_DUPLICATE = 4'd1,
    ST_FULL      = 4'd2,
    ST_DELETED   = 4'd3,
    ST_DEL_MISS  = 4'd4,
    ST_FOUND     = 4'd5,
    ST_NOT_FOUND = 4'd6,
    ST_DUMP      = 4'd7,
    ST_INVALID   = 4'd8
  } status_e;

  // Command beat
  typedef struct packed {
    cmd_e              command;
    logic [KEY_W-1:0]  key;
  } req_t;

  // Result beat
  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] address;
    logic [KEY_W-1:0]  value;
    logic              last;
  } rsp_t;

  // Slot store write control: fill marks the slot occupied, else empties it
  typedef struct packed {
    logic wr_en;
    logic fill;
  } mem_wr_t;

endpackage

@@ rtl/core/open_addressing_hash_table.sv @@
// Open-addressing hash table, top level: config registers, sequencer, slot store.
// Key command: a zero key gets an invalid result strobe in the cycle after accept, else the key is hashed
// and slots are probed until a hit or until every slot in the size is tried; dump: one beat per cycle, one per slot.
// Busy through hash, probe and dump; next accept at the edge ending the last beat.
// Sync reset empties all slots, size = 32 (clamped to depth), linear probing. Uses oaht_pkg.
`timescale 1ns / 1ps

module open_addressing_hash_table #(
  parameter int TABLE_DEPTH = 32,
  parameter int KEY_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  oaht_pkg::req_t               req,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [oaht_pkg::CFG_W-1:0]   cfg_data,
  output oaht_pkg::rsp_t               rsp,
  output logic                         strobe
);
  import oaht_pkg::*;

  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int SW       = $clog2(TABLE_DEPTH + 1);
  localparam int SIZE_RST = (TABLE_SIZE_RESET > TABLE_DEPTH) ? TABLE_DEPTH : TABLE_SIZE_RESET;

  logic [SW-1:0]       table_size;
  logic [SW-1:0]       table_size_next;
  logic                probe_mode;
  logic [AW-1:0]       mem_rd_addr;
  logic [KEY_BITS-1:0] mem_rd_key;
  mem_wr_t             mem_wr;
  logic [AW-1:0]       mem_wr_addr;
  logic [KEY_BITS-1:0] mem_wr_data;

  // Size clamped to 1 .. TABLE_DEPTH when written
  always_comb begin
    if (cfg_data == '0) begin
      table_size_next = SW'(1);
    end else if (int'(cfg_data) > TABLE_DEPTH) begin
      table_size_next = SW'(TABLE_DEPTH);
    end else begin
      table_size_next = SW'(cfg_data);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SW'(SIZE_RST);
      probe_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_SIZE: table_size <= table_size_next;
        REG_PROBE_MODE: probe_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  oaht_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .size        (table_size),
    .probe_mode  (probe_mode),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_key  (mem_rd_key),
    .mem_wr      (mem_wr),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .rsp         (rsp),
    .strobe      (strobe)
  );

  oaht_slot_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (mem_rd_addr),
    .rd_key  (mem_rd_key),
    .wr      (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

@@ rtl/core/oaht_modadd.sv @@
// Shared modular adder: (a + b) reduced once by modulus m.
// Used for the hash remainder steps and for probe address advance; uses oaht_pkg.
`timescale 1ns / 1ps

module oaht_modadd #(
  parameter int W = 6
) (
  input  logic [W:0]   a,
  input  logic [W:0]   b,
  input  logic [W-1:0] m,
  output logic [W-1:0] sum
);
  import oaht_pkg::*;

  logic [W:0] raw;

  // Operands keep a + b below 2*m, so one conditional subtract suffices
  always_comb begin
    raw = a + b;
    if (raw >= {1'b0, m}) begin
      sum = W'(raw - {1'b0, m});
    end else begin
      sum = W'(raw);
    end
  end

endmodule

@@ rtl/core/oaht_slot_mem.sv @@
// Slot store: key array with registered read plus per-slot occupied bits.
// Occupied bits clear on reset, so an unwritten slot reads as empty; uses oaht_pkg.
`timescale 1ns / 1ps

module oaht_slot_mem #(
  parameter int TABLE_DEPTH = 32,
  parameter int KEY_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic [KEY_BITS-1:0]            rd_key,
  input  oaht_pkg::mem_wr_t              wr,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic [KEY_BITS-1:0]            wr_data
);
  import oaht_pkg::*;

  logic [KEY_BITS-1:0]    mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] occupied;
  logic [KEY_BITS-1:0]    rd_data;
  logic                   rd_occupied;

  // Key array, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.wr_en && wr.fill) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Occupied bits; a delete just drops the bit
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied    <= '0;
      rd_occupied <= 1'b0;
    end else begin
      if (wr.wr_en) begin
        occupied[wr_addr] <= wr.fill;
      end
      rd_occupied <= occupied[rd_addr];
    end
  end

  assign rd_key = rd_occupied ? rd_data : '0;

endmodule

@@ rtl/core/oaht_ctrl.sv @@
// Command sequencer: bit-serial hash, pipelined slot probing, dump sweep.
// Drives the shared modular adder and the slot store; uses oaht_pkg.
`timescale 1ns / 1ps

module oaht_ctrl #(
  parameter int TABLE_DEPTH = 32,
  parameter int KEY_BITS    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  oaht_pkg::req_t                   req,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] size,
  input  logic                             probe_mode,
  output logic [$clog2(TABLE_DEPTH)-1:0]   mem_rd_addr,
  input  logic [KEY_BITS-1:0]              mem_rd_key,
  output oaht_pkg::mem_wr_t                mem_wr,
  output logic [$clog2(TABLE_DEPTH)-1:0]   mem_wr_addr,
  output logic [KEY_BITS-1:0]              mem_wr_data,
  output oaht_pkg::rsp_t                   rsp,
  output logic                             strobe
);
  import oaht_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int HB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CW = $clog2(HB);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DUMP
  } state_t;

  state_t          state;
  cmd_e            cmd_q;
  logic [HB-1:0]   key_q;
  logic [HB-1:0]   sh;
  logic [CW-1:0]   cnt;
  logic [SW-1:0]   acc;
  logic [SW-1:0]   step;
  logic [SW-1:0]   iss;
  logic            pend;
  logic            pend_last;
  logic [AW-1:0]   pend_addr;

  logic [SW:0]     u_a;
  logic [SW:0]     u_b;
  logic [SW-1:0]   u_out;
  logic [SW:0]     step_sum;
  logic [SW-1:0]   step_next;
  logic            more;
  logic            issue_last;
  logic            slot_empty;
  logic            slot_match;
  logic            found;
  logic            finish;
  status_e         probe_st;
  logic [AW-1:0]   probe_addr;

  assign busy = (state != S_IDLE);

  // Shared adder: remainder step while hashing, address advance while probing
  always_comb begin
    if (state == S_HASH) begin
      u_a = {acc, sh[HB-1]};
      u_b = '0;
    end else begin
      u_a = (SW+1)'(acc);
      u_b = (SW+1)'(step);
    end
  end

  oaht_modadd #(
    .W(SW)
  ) u_add (
    .a   (u_a),
    .b   (u_b),
    .m   (size),
    .sum (u_out)
  );

  // Quadratic offsets grow by the odd numbers: next step is step + 2 mod size
  always_comb begin
    step_sum = (SW+1)'(step) + (SW+1)'(2);
    if (step_sum >= (SW+1)'(size)) begin
      step_next = SW'(step_sum - (SW+1)'(size));
    end else begin
      step_next = SW'(step_sum);
    end
  end

  assign more       = (iss < size);
  assign issue_last = ((SW+1)'(iss) + (SW+1)'(1)) == (SW+1)'(size);

  // Probe outcome for the slot whose data arrives this cycle
  assign slot_empty = (mem_rd_key == '0);
  assign slot_match = (mem_rd_key == KEY_BITS'(key_q));
  assign found      = pend && ((cmd_q == CMD_INSERT) ? (slot_empty || slot_match) : slot_match);
  assign finish     = pend && (found || pend_last);

  always_comb begin
    probe_addr = '0;
    case (cmd_q)
      CMD_INSERT: begin
        if (slot_empty) begin
          probe_st   = ST_INSERTED;
          probe_addr = pend_addr;
        end else if (slot_match) begin
          probe_st   = ST_DUPLICATE;
          probe_addr = pend_addr;
        end else begin
          probe_st = ST_FULL;
        end
      end
      CMD_DELETE: probe_st = slot_match ? ST_DELETED : ST_DEL_MISS;
      CMD_FIND:   probe_st = slot_match ? ST_FOUND : ST_NOT_FOUND;
      default:    probe_st = ST_NOT_FOUND;
    endcase
  end

  // Slot store access
  assign mem_rd_addr  = (state == S_DUMP) ? AW'(iss) : AW'(acc);
  assign mem_wr.wr_en = (state == S_PROBE) && pend &&
                        (((cmd_q == CMD_INSERT) && slot_empty) ||
                         ((cmd_q == CMD_DELETE) && slot_match));
  assign mem_wr.fill  = (cmd_q == CMD_INSERT);
  assign mem_wr_addr  = pend_addr;
  assign mem_wr_data  = KEY_BITS'(key_q);

  // Sequencer with registered result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      pend   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= req.command;
            key_q <= req.key[HB-1:0];
            sh    <= req.key[HB-1:0];
            cnt   <= CW'(HB - 1);
            acc   <= '0;
            iss   <= '0;
            step  <= SW'(1);
            pend  <= 1'b0;
            if (req.command == CMD_DUMP) begin
              state <= S_DUMP;
            end else if (req.key[HB-1:0] == '0) begin
              rsp    <= rsp_t'{status: ST_INVALID, address: '0, value: '0, last: 1'b1};
              strobe <= 1'b1;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          // key mod size, one key bit per cycle, MSB first
          acc <= u_out;
          sh  <= sh << 1;
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          // issue one read per cycle, check the one issued last cycle
          if (more) begin
            pend      <= 1'b1;
            pend_addr <= AW'(acc);
            pend_last <= issue_last;
            acc       <= u_out;
            iss       <= iss + SW'(1);
            if (probe_mode) begin
              step <= step_next;
            end
          end else begin
            pend <= 1'b0;
          end
          if (finish) begin
            rsp    <= rsp_t'{status: probe_st, address: ADDR_W'(probe_addr),
                             value: KEY_W'(key_q), last: 1'b1};
            strobe <= 1'b1;
            pend   <= 1'b0;
            state  <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (more) begin
            pend      <= 1'b1;
            pend_addr <= AW'(iss);
            pend_last <= issue_last;
            iss       <= iss + SW'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            rsp    <= rsp_t'{status: ST_DUMP, address: ADDR_W'(pend_addr),
                             value: KEY_W'(mem_rd_key), last: pend_last};
            strobe <= 1'b1;
            if (pend_last) begin
              pend  <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Only dump beats may come without last
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (strobe && (rsp.status != ST_DUMP)) |-> rsp.last)
    else $error("key command result without last");

  // Table writes happen only on a probe hit
  a_write_in_probe: assert property (@(posedge clk) disable iff (rst)
    mem_wr.wr_en |-> ((state == S_PROBE) && pend))
    else $error("slot write outside probing");

  // A valid key command goes to hashing
  a_key_to_hash: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.command != CMD_DUMP) && (req.key[HB-1:0] != '0))
    |=> (state == S_HASH))
    else $error("accepted key command did not start hashing");

  // Never more probes than the table size
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PROBE) || (state == S_DUMP)) |-> (iss <= size))
    else $error("probe count beyond table size");

endmodule
